// ===== src/ptrp_pkg.sv =====
// shared constants, types and helpers for the point to rectangle projection pipeline
package ptrp_pkg;

	// component width and packed vector width
	localparam int CW  = 16;
	localparam int PW  = 3 * CW;
	localparam int VW  = CW + 1;          // difference of two components
	localparam int VNW = 2 * CW + 2;      // signed dot product of v and n
	localparam int MVW = 2 * CW + 1;      // magnitude of that dot product
	localparam int NNW = 2 * CW;          // squared length of a face vector
	localparam int DVW = MVW + CW;        // dividend |vn| * |n_i|
	localparam int QW  = CW + 2;          // floor quotient bits
	localparam int QRW = QW + 1;          // rounded quotient
	localparam int RQW = QRW + 1;         // signed sum of point and offset
	localparam int DW  = CW + 1;          // distance width
	localparam int SPL = (MVW + 1) / 2;   // split point of |vn| for squaring
	localparam int HW2 = 2 * (MVW - SPL);
	localparam int HLW = MVW;
	localparam int LLW = 2 * SPL;
	localparam int XW  = 2 * MVW + 2;     // 4 * vn^2
	localparam int XTW = XW + 4;          // trial value of the distance search
	localparam int TW  = NNW + DW + 2;    // (2d-1) * nn, signed
	localparam int WPW = 2 * CW + 1;      // product of w and an axis component
	localparam int WSW = WPW + 2;         // dot product of w and an axis

	// latencies
	localparam int FRONT_LAT = 5;
	localparam int UNIT_LAT  = CW + 3;
	localparam int BACK_LAT  = 4;
	localparam int PIPE_LAT  = FRONT_LAT + UNIT_LAT + BACK_LAT;

	typedef logic signed [CW-1:0] coord_t;

	// data that rides alongside the divide and distance units
	typedef struct packed {
		logic [PW-1:0]  p;
		logic [PW-1:0]  o;
		logic [PW-1:0]  a;
		logic [PW-1:0]  b;
		logic [2:0]     neg;
		logic           nz;
		logic [NNW-1:0] aa;
		logic [NNW-1:0] bb;
	} side_t;

	// front end results handed to the units
	typedef struct packed {
		logic [2:0][DVW-1:0] dvd;
		logic [HW2-1:0]      hh;
		logic [HLW-1:0]      hl;
		logic [LLW-1:0]      ll;
		logic [NNW-1:0]      nn;
		side_t               side;
	} front_t;

	// component i of a packed vector
	function automatic coord_t comp(input logic [PW-1:0] w, input int i);
		return coord_t'(w[i*CW +: CW]);
	endfunction

	// clamp to the signed component range
	function automatic coord_t sat_coord(input logic signed [RQW-1:0] v);
		logic signed [RQW-1:0] mx;
		logic signed [RQW-1:0] mn;
		mx = RQW'(coord_t'({1'b0, {(CW-1){1'b1}}}));
		mn = RQW'(coord_t'({1'b1, {(CW-1){1'b0}}}));
		if (v > mx) begin
			return coord_t'(mx);
		end else if (v < mn) begin
			return coord_t'(mn);
		end
		return coord_t'(v);
	endfunction

endpackage

// ===== src/ptrp_query_if.sv =====
// query channel: point and face, valid/ready
interface ptrp_query_if;
	logic                     valid;
	logic                     ready;
	logic [ptrp_pkg::PW-1:0]  point;
	logic [ptrp_pkg::PW-1:0]  face_origin;
	logic [ptrp_pkg::PW-1:0]  face_normal;
	logic [ptrp_pkg::PW-1:0]  face_x_half;
	logic [ptrp_pkg::PW-1:0]  face_y_half;

	modport source (output valid, point, face_origin, face_normal, face_x_half, face_y_half,
		input ready);
	modport sink (input valid, point, face_origin, face_normal, face_x_half, face_y_half,
		output ready);
endinterface

// ===== src/ptrp_result_if.sv =====
// result channel: projection, distance and inside flag, valid/ready
interface ptrp_result_if;
	logic                     valid;
	logic                     ready;
	logic [ptrp_pkg::PW-1:0]  projected;
	logic [ptrp_pkg::DW-1:0]  plane_distance;
	logic                     inside_res;

	modport source (output valid, projected, plane_distance, inside_res, input ready);
	modport sink (input valid, projected, plane_distance, inside_res, output ready);
endinterface

// ===== src/ptrp_front.sv =====
// front end: differences, dot products, magnitudes and partial products
module ptrp_front (
	input  logic                    clk,
	input  logic                    en,
	input  logic [ptrp_pkg::PW-1:0] point,
	input  logic [ptrp_pkg::PW-1:0] face_origin,
	input  logic [ptrp_pkg::PW-1:0] face_normal,
	input  logic [ptrp_pkg::PW-1:0] face_x_half,
	input  logic [ptrp_pkg::PW-1:0] face_y_half,
	output ptrp_pkg::front_t        f
);

	logic [ptrp_pkg::PW-1:0] p_s1, o_s1, n_s1, a_s1, b_s1;
	logic signed [ptrp_pkg::VW-1:0] v_s1 [3];

	logic [ptrp_pkg::PW-1:0] p_s2, o_s2, n_s2, a_s2, b_s2;
	logic signed [ptrp_pkg::VW+ptrp_pkg::CW-1:0] vnp_s2 [3];
	logic signed [2*ptrp_pkg::CW-1:0] nnp_s2 [3];
	logic signed [2*ptrp_pkg::CW-1:0] aap_s2 [3];
	logic signed [2*ptrp_pkg::CW-1:0] bbp_s2 [3];

	logic [ptrp_pkg::PW-1:0] p_s3, o_s3, n_s3, a_s3, b_s3;
	logic signed [ptrp_pkg::VNW-1:0] vn_s3;
	logic [ptrp_pkg::NNW-1:0] nn_s3, aa_s3, bb_s3;

	logic [ptrp_pkg::PW-1:0] p_s4, o_s4, a_s4, b_s4;
	logic [ptrp_pkg::MVW-1:0] mvn_s4;
	logic [ptrp_pkg::CW-1:0] nm_s4 [3];
	logic [2:0] neg_s4;
	logic nz_s4;
	logic [ptrp_pkg::NNW-1:0] nn_s4, aa_s4, bb_s4;

	ptrp_pkg::front_t f_s5;

	logic [ptrp_pkg::MVW-ptrp_pkg::SPL-1:0] mh;
	logic [ptrp_pkg::SPL-1:0] ml;

	// stage 1: capture and take point minus origin
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= point;
			o_s1 <= face_origin;
			n_s1 <= face_normal;
			a_s1 <= face_x_half;
			b_s1 <= face_y_half;
			for (int i = 0; i < 3; i++) begin
				v_s1[i] <= ptrp_pkg::VW'(ptrp_pkg::comp(point, i))
					- ptrp_pkg::VW'(ptrp_pkg::comp(face_origin, i));
			end
		end
	end

	// stage 2: component products
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= p_s1;
			o_s2 <= o_s1;
			n_s2 <= n_s1;
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			for (int i = 0; i < 3; i++) begin
				vnp_s2[i] <= v_s1[i] * ptrp_pkg::comp(n_s1, i);
				nnp_s2[i] <= ptrp_pkg::comp(n_s1, i) * ptrp_pkg::comp(n_s1, i);
				aap_s2[i] <= ptrp_pkg::comp(a_s1, i) * ptrp_pkg::comp(a_s1, i);
				bbp_s2[i] <= ptrp_pkg::comp(b_s1, i) * ptrp_pkg::comp(b_s1, i);
			end
		end
	end

	// stage 3: sum the products
	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= p_s2;
			o_s3 <= o_s2;
			n_s3 <= n_s2;
			a_s3 <= a_s2;
			b_s3 <= b_s2;
			vn_s3 <= ptrp_pkg::VNW'(vnp_s2[0]) + ptrp_pkg::VNW'(vnp_s2[1])
				+ ptrp_pkg::VNW'(vnp_s2[2]);
			nn_s3 <= $unsigned(nnp_s2[0]) + $unsigned(nnp_s2[1]) + $unsigned(nnp_s2[2]);
			aa_s3 <= $unsigned(aap_s2[0]) + $unsigned(aap_s2[1]) + $unsigned(aap_s2[2]);
			bb_s3 <= $unsigned(bbp_s2[0]) + $unsigned(bbp_s2[1]) + $unsigned(bbp_s2[2]);
		end
	end

	// stage 4: magnitudes and offset signs
	always_ff @(posedge clk) begin
		if (en) begin
			p_s4 <= p_s3;
			o_s4 <= o_s3;
			a_s4 <= a_s3;
			b_s4 <= b_s3;
			nn_s4 <= nn_s3;
			aa_s4 <= aa_s3;
			bb_s4 <= bb_s3;
			nz_s4 <= (nn_s3 != '0);
			mvn_s4 <= ptrp_pkg::MVW'(vn_s3[ptrp_pkg::VNW-1] ? -vn_s3 : vn_s3);
			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= vn_s3[ptrp_pkg::VNW-1] ^ n_s3[i*ptrp_pkg::CW + ptrp_pkg::CW-1];
				nm_s4[i] <= ptrp_pkg::CW'(n_s3[i*ptrp_pkg::CW + ptrp_pkg::CW-1]
					? -ptrp_pkg::VW'(ptrp_pkg::comp(n_s3, i))
					: ptrp_pkg::VW'(ptrp_pkg::comp(n_s3, i)));
			end
		end
	end

	assign mh = mvn_s4[ptrp_pkg::MVW-1:ptrp_pkg::SPL];
	assign ml = mvn_s4[ptrp_pkg::SPL-1:0];

	// stage 5: dividends and partial products of vn squared
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				f_s5.dvd[i] <= ptrp_pkg::DVW'(mvn_s4) * ptrp_pkg::DVW'(nm_s4[i]);
			end
			f_s5.hh <= ptrp_pkg::HW2'(mh) * ptrp_pkg::HW2'(mh);
			f_s5.hl <= ptrp_pkg::HLW'(mh) * ptrp_pkg::HLW'(ml);
			f_s5.ll <= ptrp_pkg::LLW'(ml) * ptrp_pkg::LLW'(ml);
			f_s5.nn <= nn_s4;
			f_s5.side.p <= p_s4;
			f_s5.side.o <= o_s4;
			f_s5.side.a <= a_s4;
			f_s5.side.b <= b_s4;
			f_s5.side.neg <= neg_s4;
			f_s5.side.nz <= nz_s4;
			f_s5.side.aa <= aa_s4;
			f_s5.side.bb <= bb_s4;
		end
	end

	assign f = f_s5;

endmodule

// ===== src/ptrp_div.sv =====
// pipelined restoring divider, one quotient bit per stage, rounded half up
module ptrp_div (
	input  logic                     clk,
	input  logic                     en,
	input  logic [ptrp_pkg::DVW-1:0] dvd,
	input  logic [ptrp_pkg::NNW-1:0] dsr,
	output logic [ptrp_pkg::QRW-1:0] quo
);

	logic [ptrp_pkg::NNW-1:0] rem_s [ptrp_pkg::QW];
	logic [ptrp_pkg::QW-1:0]  lo_s  [ptrp_pkg::QW];
	logic [ptrp_pkg::NNW-1:0] dsr_s [ptrp_pkg::QW];
	logic [ptrp_pkg::QW-1:0]  q_s   [ptrp_pkg::QW];
	logic [ptrp_pkg::QRW-1:0] quo_s;

	for (genvar j = 0; j < ptrp_pkg::QW; j++) begin : g_bit
		logic [ptrp_pkg::NNW-1:0] rem_i;
		logic [ptrp_pkg::QW-1:0]  lo_i;
		logic [ptrp_pkg::NNW-1:0] dsr_i;
		logic [ptrp_pkg::QW-1:0]  q_i;
		logic [ptrp_pkg::NNW:0]   trial;
		logic [ptrp_pkg::NNW:0]   diff;
		logic                     take;

		// stage inputs: the port for the first bit, the previous stage otherwise
		if (j == 0) begin : g_first
			assign rem_i = ptrp_pkg::NNW'(dvd[ptrp_pkg::DVW-1:ptrp_pkg::QW]);
			assign lo_i  = dvd[ptrp_pkg::QW-1:0];
			assign dsr_i = dsr;
			assign q_i   = '0;
		end else begin : g_next
			assign rem_i = rem_s[j-1];
			assign lo_i  = lo_s[j-1];
			assign dsr_i = dsr_s[j-1];
			assign q_i   = q_s[j-1];
		end

		// shift in the next dividend bit and try the subtract
		assign trial = {rem_i, lo_i[ptrp_pkg::QW-1-j]};
		assign diff  = trial - {1'b0, dsr_i};
		assign take  = (trial >= {1'b0, dsr_i});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= take ? ptrp_pkg::NNW'(diff) : ptrp_pkg::NNW'(trial);
				lo_s[j]  <= lo_i;
				dsr_s[j] <= dsr_i;
				q_s[j]   <= {q_i[ptrp_pkg::QW-2:0], take};
			end
		end
	end

	// round half up from the final remainder
	always_ff @(posedge clk) begin
		if (en) begin
			quo_s <= ptrp_pkg::QRW'(q_s[ptrp_pkg::QW-1])
				+ ptrp_pkg::QRW'({rem_s[ptrp_pkg::QW-1], 1'b0} >= {1'b0, dsr_s[ptrp_pkg::QW-1]});
		end
	end

	assign quo = quo_s;

endmodule

// ===== src/ptrp_dist.sv =====
// distance |vn| / |n| rounded half up, one result bit per stage, no multipliers
module ptrp_dist (
	input  logic                     clk,
	input  logic                     en,
	input  logic [ptrp_pkg::HW2-1:0] hh,
	input  logic [ptrp_pkg::HLW-1:0] hl,
	input  logic [ptrp_pkg::LLW-1:0] ll,
	input  logic [ptrp_pkg::NNW-1:0] nn,
	input  logic                     nz,
	output logic [ptrp_pkg::DW-1:0]  distance
);

	logic [ptrp_pkg::XW-1:0]  x_s0;
	logic [ptrp_pkg::NNW-1:0] nn_s0;
	logic                     nz_s0;

	logic [ptrp_pkg::XW-1:0]        x_s  [ptrp_pkg::DW];
	logic [ptrp_pkg::XW-1:0]        sq_s [ptrp_pkg::DW];
	logic signed [ptrp_pkg::TW-1:0] tl_s [ptrp_pkg::DW];
	logic [ptrp_pkg::NNW-1:0]       nn_s [ptrp_pkg::DW];
	logic                           nz_s [ptrp_pkg::DW];
	logic [ptrp_pkg::DW-1:0]        d_s  [ptrp_pkg::DW];
	logic [ptrp_pkg::DW-1:0]        out_s;

	// assemble 4 * vn^2 from the partial products
	always_ff @(posedge clk) begin
		if (en) begin
			x_s0 <= ((ptrp_pkg::XW'(hh) << (2 * ptrp_pkg::SPL))
				+ (ptrp_pkg::XW'(hl) << (ptrp_pkg::SPL + 1))
				+ ptrp_pkg::XW'(ll)) << 2;
			nn_s0 <= nn;
			nz_s0 <= nz;
		end
	end

	// keep sq = (2d-1)^2 * nn and tl = (2d-1) * nn for the current d
	for (genvar j = 0; j < ptrp_pkg::DW; j++) begin : g_dig
		localparam int K = ptrp_pkg::DW - 1 - j;
		logic [ptrp_pkg::XW-1:0]        x_i;
		logic [ptrp_pkg::XW-1:0]        sq_i;
		logic signed [ptrp_pkg::TW-1:0] tl_i;
		logic [ptrp_pkg::NNW-1:0]       nn_i;
		logic                           nz_i;
		logic [ptrp_pkg::DW-1:0]        d_i;
		logic [ptrp_pkg::XTW-1:0]       tst;
		logic                           take;

		if (j == 0) begin : g_first
			assign x_i  = x_s0;
			assign sq_i = ptrp_pkg::XW'(nn_s0);
			assign tl_i = -$signed(ptrp_pkg::TW'(nn_s0));
			assign nn_i = nn_s0;
			assign nz_i = nz_s0;
			assign d_i  = '0;
		end else begin : g_next
			assign x_i  = x_s[j-1];
			assign sq_i = sq_s[j-1];
			assign tl_i = tl_s[j-1];
			assign nn_i = nn_s[j-1];
			assign nz_i = nz_s[j-1];
			assign d_i  = d_s[j-1];
		end

		// square of the candidate odd number times nn
		assign tst = ptrp_pkg::XTW'(sq_i)
			+ (ptrp_pkg::XTW'(tl_i) << (K + 2))
			+ (ptrp_pkg::XTW'(nn_i) << (2 * K + 2));
		assign take = (tst <= ptrp_pkg::XTW'(x_i));

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[j]  <= x_i;
				nn_s[j] <= nn_i;
				nz_s[j] <= nz_i;
				sq_s[j] <= take ? ptrp_pkg::XW'(tst) : sq_i;
				tl_s[j] <= take ? tl_i + $signed(ptrp_pkg::TW'(nn_i) << (K + 1)) : tl_i;
				d_s[j]  <= d_i | (ptrp_pkg::DW'(take) << K);
			end
		end
	end

	// zero normal gives zero distance
	always_ff @(posedge clk) begin
		if (en) begin
			out_s <= nz_s[ptrp_pkg::DW-1] ? d_s[ptrp_pkg::DW-1] : '0;
		end
	end

	assign distance = out_s;

endmodule

// ===== src/point_to_rectangle_projection.sv =====
// top level: point to rectangle projection pipeline with output register
//
//  channel  dir  beat contents
//  query    in   point, face_origin, face_normal, face_x_half, face_y_half
//  result   out  projected, plane_distance, inside_res
//
// one query per cycle when not stalled; a result passes through 5 front stages,
// 19 divide/distance stages set by one quotient bit per stage,
// 4 back stages, then the output register
// reset clears only the valid bits; no clearing pass
// the pipeline stalls only when its last stage holds a beat and the output
// register holds one that is not taken
module point_to_rectangle_projection (
	input  logic          clk,
	input  logic          arst_n,
	ptrp_query_if.sink    query,
	ptrp_result_if.source result
);

	ptrp_pkg::front_t f;
	ptrp_pkg::side_t  side_s [ptrp_pkg::UNIT_LAT];
	ptrp_pkg::side_t  sd;

	logic [ptrp_pkg::PIPE_LAT-1:0] vld_s;
	logic adv;

	logic [ptrp_pkg::QRW-1:0] quo [3];
	logic [ptrp_pkg::DW-1:0]  dist_u;

	ptrp_pkg::coord_t qc [3];

	logic [ptrp_pkg::PW-1:0]  q_s25, o_s25, a_s25, b_s25;
	logic [ptrp_pkg::NNW-1:0] aa_s25, bb_s25;
	logic [ptrp_pkg::DW-1:0]  dist_s25;

	logic signed [ptrp_pkg::VW-1:0] w_s26 [3];
	logic [ptrp_pkg::PW-1:0]  q_s26, a_s26, b_s26;
	logic [ptrp_pkg::NNW-1:0] aa_s26, bb_s26;
	logic [ptrp_pkg::DW-1:0]  dist_s26;

	logic signed [ptrp_pkg::WPW-1:0] wap_s27 [3];
	logic signed [ptrp_pkg::WPW-1:0] wbp_s27 [3];
	logic [ptrp_pkg::PW-1:0]  q_s27;
	logic [ptrp_pkg::NNW-1:0] aa_s27, bb_s27;
	logic [ptrp_pkg::DW-1:0]  dist_s27;

	logic signed [ptrp_pkg::WSW-1:0] wa_s28, wb_s28;
	logic [ptrp_pkg::PW-1:0]  q_s28;
	logic [ptrp_pkg::NNW-1:0] aa_s28, bb_s28;
	logic [ptrp_pkg::DW-1:0]  dist_s28;

	logic [ptrp_pkg::WSW-1:0] wa_mag, wb_mag;

	logic                     ovld_q;
	logic [ptrp_pkg::PW-1:0]  proj_q;
	logic [ptrp_pkg::DW-1:0]  dist_q;
	logic                     inside_q;

	// pipeline moves unless the last stage is blocked by a held result
	assign adv = !vld_s[ptrp_pkg::PIPE_LAT-1] || !ovld_q || result.ready;
	assign query.ready = adv;

	// valid bits travel with the beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[ptrp_pkg::PIPE_LAT-2:0], query.valid};
		end
	end

	ptrp_front u_front (
		.clk         (clk),
		.en          (adv),
		.point       (query.point),
		.face_origin (query.face_origin),
		.face_normal (query.face_normal),
		.face_x_half (query.face_x_half),
		.face_y_half (query.face_y_half),
		.f           (f)
	);

	for (genvar i = 0; i < 3; i++) begin : g_div
		ptrp_div u_div (
			.clk (clk),
			.en  (adv),
			.dvd (f.dvd[i]),
			.dsr (f.nn),
			.quo (quo[i])
		);
	end

	ptrp_dist u_dist (
		.clk      (clk),
		.en       (adv),
		.hh       (f.hh),
		.hl       (f.hl),
		.ll       (f.ll),
		.nn       (f.nn),
		.nz       (f.side.nz),
		.distance (dist_u)
	);

	// side data delayed to line up with the units
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= f.side;
			for (int j = 1; j < ptrp_pkg::UNIT_LAT; j++) begin
				side_s[j] <= side_s[j-1];
			end
		end
	end

	assign sd = side_s[ptrp_pkg::UNIT_LAT-1];

	// apply the rounded offset and saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (sd.nz) begin
				qc[i] = ptrp_pkg::sat_coord(sd.neg[i]
					? ptrp_pkg::RQW'(ptrp_pkg::comp(sd.p, i)) + $signed({1'b0, quo[i]})
					: ptrp_pkg::RQW'(ptrp_pkg::comp(sd.p, i)) - $signed({1'b0, quo[i]}));
			end else begin
				qc[i] = ptrp_pkg::comp(sd.p, i);
			end
		end
	end

	// stage 25: projected point
	always_ff @(posedge clk) begin
		if (adv) begin
			q_s25 <= {qc[2], qc[1], qc[0]};
			o_s25 <= sd.o;
			a_s25 <= sd.a;
			b_s25 <= sd.b;
			aa_s25 <= sd.aa;
			bb_s25 <= sd.bb;
			dist_s25 <= dist_u;
		end
	end

	// stage 26: offset of the projection from the face center
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				w_s26[i] <= ptrp_pkg::VW'(ptrp_pkg::comp(q_s25, i))
					- ptrp_pkg::VW'(ptrp_pkg::comp(o_s25, i));
			end
			q_s26 <= q_s25;
			a_s26 <= a_s25;
			b_s26 <= b_s25;
			aa_s26 <= aa_s25;
			bb_s26 <= bb_s25;
			dist_s26 <= dist_s25;
		end
	end

	// stage 27: products with the axes
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				wap_s27[i] <= w_s26[i] * ptrp_pkg::comp(a_s26, i);
				wbp_s27[i] <= w_s26[i] * ptrp_pkg::comp(b_s26, i);
			end
			q_s27 <= q_s26;
			aa_s27 <= aa_s26;
			bb_s27 <= bb_s26;
			dist_s27 <= dist_s26;
		end
	end

	// stage 28: axis dot products
	always_ff @(posedge clk) begin
		if (adv) begin
			wa_s28 <= ptrp_pkg::WSW'(wap_s27[0]) + ptrp_pkg::WSW'(wap_s27[1])
				+ ptrp_pkg::WSW'(wap_s27[2]);
			wb_s28 <= ptrp_pkg::WSW'(wbp_s27[0]) + ptrp_pkg::WSW'(wbp_s27[1])
				+ ptrp_pkg::WSW'(wbp_s27[2]);
			q_s28 <= q_s27;
			aa_s28 <= aa_s27;
			bb_s28 <= bb_s27;
			dist_s28 <= dist_s27;
		end
	end

	assign wa_mag = wa_s28[ptrp_pkg::WSW-1] ? $unsigned(-wa_s28) : $unsigned(wa_s28);
	assign wb_mag = wb_s28[ptrp_pkg::WSW-1] ? $unsigned(-wb_s28) : $unsigned(wb_s28);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (adv && vld_s[ptrp_pkg::PIPE_LAT-1]) begin
			ovld_q <= 1'b1;
		end else if (result.ready) begin
			ovld_q <= 1'b0;
		end
	end

	// output register payload and rectangle test
	always_ff @(posedge clk) begin
		if (adv && vld_s[ptrp_pkg::PIPE_LAT-1]) begin
			proj_q <= q_s28;
			dist_q <= dist_s28;
			inside_q <= (aa_s28 != '0) && (bb_s28 != '0)
				&& (wa_mag <= ptrp_pkg::WSW'(aa_s28))
				&& (wb_mag <= ptrp_pkg::WSW'(bb_s28));
		end
	end

	assign result.valid          = ovld_q;
	assign result.projected      = proj_q;
	assign result.plane_distance = dist_q;
	assign result.inside_res     = inside_q;

	// a taken result with nothing behind it empties the output register
	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q && result.ready && !vld_s[ptrp_pkg::PIPE_LAT-1] |=> !ovld_q)
		else $error("output register did not drain");

	// a stalled last stage keeps its beat and its data
	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ptrp_pkg::PIPE_LAT-1] && !adv
		|=> vld_s[ptrp_pkg::PIPE_LAT-1] && $stable(wa_s28) && $stable(q_s28))
		else $error("last stage lost its beat during a stall");

	// an accepted query beat enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		query.valid && query.ready |=> vld_s[0])
		else $error("accepted beat did not enter the pipeline");

endmodule

// ===== test/tb_ptrp_ifs.sv =====
// testbench-side note: interfaces come from the rtl sources; this file holds the expected-result type
`timescale 1ns / 100ps
package tb_ptrp_types;
	typedef struct {
		logic [47:0] projected;
		logic [16:0] plane_distance;
		logic        inside_res;
	} projection_t;
endpackage

// ===== test/tb_point_to_rectangle_projection.sv =====
// testbench for the point to rectangle projection pipeline: random and directed queries
`timescale 1ns / 100ps
module tb_point_to_rectangle_projection;

	typedef struct {
		logic [ptrp_pkg::PW-1:0] p, o, n, a, b;
	} query_t;

	logic clk;
	logic arst_n;
	ptrp_query_if  query ();
	ptrp_result_if result ();

	point_to_rectangle_projection i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query.sink),
		.result (result.source)
	);

	query_t                    pending_q[$];
	tb_ptrp_types::projection_t expected_q[$];
	int                        send_idle_pct;
	int                        recv_stall_pct;
	int                        mismatches;
	bit                        q_fire;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// signed component of a packed word
	function automatic longint cval(logic [ptrp_pkg::PW-1:0] w, int i);
		return longint'($signed(w[i*ptrp_pkg::CW +: ptrp_pkg::CW]));
	endfunction

	function automatic longint iabs(longint x);
		return x < 0 ? -x : x;
	endfunction

	// exact projection, distance and inside test on raw codes
	function automatic tb_ptrp_types::projection_t project_onto_face(query_t qr);
		tb_ptrp_types::projection_t r;
		longint vn, nn, aa, bb, wa, wb, s, qv, lim;
		longint qc[3];
		logic [127:0] num, quo, rem, lhs, rhs, cand;
		logic [16:0] pdist;
		vn = 0; nn = 0; aa = 0; bb = 0; wa = 0; wb = 0; pdist = '0;
		lim = (64'sd1 << (ptrp_pkg::CW - 1));
		for (int i = 0; i < 3; i++) begin
			vn += (cval(qr.p, i) - cval(qr.o, i)) * cval(qr.n, i);
			nn += cval(qr.n, i) * cval(qr.n, i);
			aa += cval(qr.a, i) * cval(qr.a, i);
			bb += cval(qr.b, i) * cval(qr.b, i);
		end
		for (int i = 0; i < 3; i++) begin
			if (nn == 0) begin
				qc[i] = cval(qr.p, i);
			end else begin
				num = 128'(iabs(vn)) * 128'(iabs(cval(qr.n, i)));
				quo = num / 128'(nn);
				rem = num % 128'(nn);
				if (rem * 2 >= 128'(nn)) quo = quo + 1;
				s = longint'(quo);
				qv = ((vn < 0) != (cval(qr.n, i) < 0)) ? cval(qr.p, i) + s : cval(qr.p, i) - s;
				if (qv > lim - 1) qv = lim - 1;
				if (qv < -lim) qv = -lim;
				qc[i] = qv;
			end
		end
		// largest d with (2d-1)^2 * nn <= (2|vn|)^2
		if (nn != 0) begin
			rhs = 128'(2 * iabs(vn)) * 128'(2 * iabs(vn));
			for (int k = ptrp_pkg::CW; k >= 0; k--) begin
				cand = 128'(pdist) | (128'd1 << k);
				lhs = (2 * cand - 1) * (2 * cand - 1) * 128'(nn);
				if (lhs <= rhs) pdist = cand[16:0];
			end
		end
		for (int i = 0; i < 3; i++) begin
			wa += (qc[i] - cval(qr.o, i)) * cval(qr.a, i);
			wb += (qc[i] - cval(qr.o, i)) * cval(qr.b, i);
			r.projected[i*ptrp_pkg::CW +: ptrp_pkg::CW] = qc[i][ptrp_pkg::CW-1:0];
		end
		r.plane_distance = pdist;
		r.inside_res = (aa != 0 && bb != 0 && iabs(wa) <= aa && iabs(wb) <= bb);
		return r;
	endfunction

	// packed vector from three components
	function automatic logic [ptrp_pkg::PW-1:0] vec3(int x, int y, int z);
		logic [ptrp_pkg::PW-1:0] w;
		w = {z[15:0], y[15:0], x[15:0]};
		return w;
	endfunction

	function automatic logic [ptrp_pkg::PW-1:0] rand_vec();
		return ptrp_pkg::PW'({$urandom, $urandom});
	endfunction

	// small component, sometimes extreme
	function automatic logic [ptrp_pkg::PW-1:0] mild_vec(int span);
		logic [ptrp_pkg::PW-1:0] w;
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(0, 9))
				0: w[i*ptrp_pkg::CW +: ptrp_pkg::CW] = 16'h7fff;
				1: w[i*ptrp_pkg::CW +: ptrp_pkg::CW] = 16'h8000;
				2: w[i*ptrp_pkg::CW +: ptrp_pkg::CW] = '0;
				default: w[i*ptrp_pkg::CW +: ptrp_pkg::CW] =
					16'($urandom_range(0, 2 * span) - span);
			endcase
		end
		return w;
	endfunction

	task automatic push_query(logic [ptrp_pkg::PW-1:0] p, o, n, a, b);
		query_t qr;
		qr.p = p; qr.o = o; qr.n = n; qr.a = a; qr.b = b;
		pending_q.push_back(qr);
	endtask

	// query beat monitor: record accepted beats and their expected results
	always @(posedge clk) begin
		q_fire <= arst_n && query.valid && query.ready;
		if (arst_n && query.valid && query.ready) begin
			expected_q.push_back(project_onto_face(
				'{query.point, query.face_origin, query.face_normal,
				  query.face_x_half, query.face_y_half}));
		end
	end

	// sender: change at falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!query.valid || q_fire) begin
				if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					query_t qr;
					qr = pending_q.pop_front();
					query.valid       <= 1'b1;
					query.point       <= qr.p;
					query.face_origin <= qr.o;
					query.face_normal <= qr.n;
					query.face_x_half <= qr.a;
					query.face_y_half <= qr.b;
				end else begin
					query.valid <= 1'b0;
				end
			end
			result.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// result beat checker
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %h", result.projected);
			end else begin
				tb_ptrp_types::projection_t e;
				e = expected_q.pop_front();
				if (result.projected !== e.projected || result.plane_distance !== e.plane_distance
						|| result.inside_res !== e.inside_res) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h %h %b got %h %h %b", e.projected,
							e.plane_distance, e.inside_res, result.projected,
							result.plane_distance, result.inside_res);
				end
			end
		end
	end

	// stimulus and phases
	initial begin
		int a, b, span;
		query.valid = 1'b0;
		query.point = '0; query.face_origin = '0; query.face_normal = '0;
		query.face_x_half = '0; query.face_y_half = '0;
		result.ready = 1'b0;
		mismatches = 0; send_idle_pct = 0; recv_stall_pct = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		// directed: zero normal, zero axis, extremes, saturation, boundary
		push_query(vec3(100, -50, 7), vec3(3, 4, 5), '0, vec3(16, 0, 0), vec3(0, 16, 0));
		push_query(vec3(10, 10, 50), '0, vec3(0, 0, 16), '0, vec3(0, 16, 0));
		push_query(vec3(10, 10, 50), '0, vec3(0, 0, 16), vec3(16, 0, 0), '0);
		push_query(vec3(10, 10, 50), '0, vec3(0, 0, 16), vec3(16, 0, 0), vec3(0, 16, 0));
		push_query(vec3(16, 16, 50), '0, vec3(0, 0, 1), vec3(16, 0, 0), vec3(0, 16, 0));
		push_query(vec3(17, 16, -50), '0, vec3(0, 0, -3), vec3(16, 0, 0), vec3(0, 16, 0));
		push_query({ptrp_pkg::PW{1'b1}} >> 1, {ptrp_pkg::PW{1'b0}}, vec3(1, 1, 1),
			vec3(5, 5, 5), vec3(3, -3, 0));
		push_query(vec3(32767, 32767, 32767), vec3(-32768, -32768, -32768),
			vec3(32767, 32767, 32767), vec3(32767, 0, 0), vec3(0, 32767, 0));
		push_query(vec3(-32768, -32768, -32768), vec3(32767, 32767, 32767),
			vec3(-32768, -32768, -32768), vec3(-32768, 0, 0), vec3(0, -32768, 0));
		push_query(vec3(32767, -32768, 0), vec3(-32768, 32767, 0), vec3(1, 0, 0),
			vec3(-32768, -32768, -32768), vec3(32767, 32767, 32767));
		push_query(vec3(1, 2, 3), vec3(1, 2, 3), vec3(-7, 2, 9), vec3(4, 4, 0), vec3(0, 1, 1));
		push_query(vec3(5, 0, 0), '0, vec3(1, 1, 0), vec3(1, -1, 0), vec3(0, 0, 1));
		push_query({ptrp_pkg::PW{1'b1}}, {ptrp_pkg::PW{1'b1}}, {ptrp_pkg::PW{1'b1}},
			{ptrp_pkg::PW{1'b1}}, {ptrp_pkg::PW{1'b1}});
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
				3: begin send_idle_pct = 27; recv_stall_pct = 27; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (int i = 0; i < 400; i++) begin
				span = ($urandom_range(0, 1)) ? 64 : 4000;
				case ($urandom_range(0, 9))
					0: push_query(rand_vec(), rand_vec(), rand_vec(), rand_vec(), rand_vec());
					1: push_query(mild_vec(span), mild_vec(span), '0, mild_vec(span),
						mild_vec(span));
					default: begin
						// axis-aligned face so inside results occur often
						a = $urandom_range(1, span);
						b = $urandom_range(1, span);
						push_query(mild_vec(span), mild_vec(64),
							($urandom_range(0, 3) == 0) ? mild_vec(span) :
							vec3(0, 0, $urandom_range(1, 300)),
							($urandom_range(0, 9) == 0) ? '0 : vec3(a, 0, 0),
							vec3(0, ($urandom_range(0, 1) ? b : -b), 0));
					end
				endcase
			end
			while (pending_q.size() != 0 || query.valid) @(posedge clk);
		end
		while (expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("point_to_rectangle_projection regression: pass");
		end else begin
			$display("point_to_rectangle_projection regression: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("point_to_rectangle_projection regression: fail");
		$finish;
	end
endmodule
